// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the oxygen voxel calculator RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside of reset.
`define POXC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen outside of reset.
`define POXC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/poxc_pkg.sv =====
// ---------------------------------------------------------------------------
// poxc_pkg
// Types, constants and fixed-point helpers of the oxygen voxel calculator.
// ---------------------------------------------------------------------------
package poxc_pkg;

	localparam int DATA_W      = 32;
	localparam int FRAC_W      = 16;
	localparam int QUO_W       = DATA_W + FRAC_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int SETTLE_CYC  = 5;

	// Constant-divide helpers: magnitudes below 2**CMAG_W
	localparam int CMAG_W    = DATA_W + 4;
	localparam int RCP_SHIFT = CMAG_W + 1;
	localparam int RCP_W     = RCP_SHIFT + 1;
	localparam logic [RCP_W-1:0] RCP_2000 = RCP_W'((64'd1 << RCP_SHIFT) / 64'd2000);
	localparam logic [RCP_W-1:0] RCP_200  = RCP_W'((64'd1 << RCP_SHIFT) / 64'd200);
	localparam logic [RCP_W-1:0] RCP_21   = RCP_W'((64'd1 << RCP_SHIFT) / 64'd21);

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [DATA_W-1:0]        umag_t;

	localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam data_t OEF_TOP  = DATA_W'(64'd1000 << FRAC_W);

	typedef enum logic [2:0] {
		REG_MODE,
		REG_WATER_A,
		REG_WATER_B,
		REG_OXY_A,
		REG_OXY_B,
		REG_BLOOD_O2,
		REG_PET_CONV,
		REG_SCALE
	} reg_idx_t;

	typedef struct packed {
		logic  mode;
		data_t wa;
		data_t wb;
		data_t oa;
		data_t ob;
		data_t scale;
		data_t c1;
		data_t c2;
		data_t c3;
	} cfg_t;

	typedef struct packed {
		data_t x1;
		data_t x2;
		data_t x3;
		logic  last;
		logic  zero_cnt;
	} item_t;

	typedef struct packed {
		logic zero_cnt;
		logic zero_den;
		logic last;
		logic neg;
	} ctl_t;

	function automatic umag_t mag(data_t a);
		mag = a[DATA_W-1] ? umag_t'(-a) : umag_t'(a);
	endfunction

	// Q-format multiply, magnitude truncated, saturated
	function automatic data_t fmul(data_t a, data_t b);
		logic [2*DATA_W-1:0] prod;
		logic [QUO_W-1:0]    sh;
		logic [QUO_W-1:0]    lim;
		logic                neg;
		neg  = a[DATA_W-1] ^ b[DATA_W-1];
		prod = mag(a) * mag(b);
		sh   = prod[2*DATA_W-1:FRAC_W];
		lim  = neg ? QUO_W'(mag(DATA_MIN)) : QUO_W'(DATA_MAX);
		if (sh > lim) sh = lim;
		if (neg) sh = ~sh + QUO_W'(1);
		fmul = sh[DATA_W-1:0];
	endfunction

	function automatic data_t sat_sum(logic signed [DATA_W:0] s);
		if (s[DATA_W] != s[DATA_W-1])
			sat_sum = s[DATA_W] ? DATA_MIN : DATA_MAX;
		else
			sat_sum = s[DATA_W-1:0];
	endfunction

	function automatic data_t sat_add(data_t a, data_t b);
		sat_add = sat_sum({a[DATA_W-1], a} + {b[DATA_W-1], b});
	endfunction

	function automatic data_t sat_sub(data_t a, data_t b);
		sat_sub = sat_sum({a[DATA_W-1], a} - {b[DATA_W-1], b});
	endfunction

	// Quotient estimate by reciprocal multiply, low by at most one
	function automatic logic [CMAG_W-1:0] cd_est(logic [CMAG_W-1:0] p, logic [RCP_W-1:0] m);
		logic [CMAG_W+RCP_W-1:0] full;
		full   = p * m;
		cd_est = full[CMAG_W+RCP_SHIFT-1:RCP_SHIFT];
	endfunction

	// One correction step, then sign applied (rounds toward zero)
	function automatic data_t cd_fix(logic [CMAG_W-1:0] p, logic [CMAG_W-1:0] q,
			logic [11:0] d, logic neg);
		logic [CMAG_W-1:0] r;
		logic [CMAG_W-1:0] qc;
		r  = p - CMAG_W'(q * d);
		qc = (r >= CMAG_W'(d)) ? q + CMAG_W'(1) : q;
		cd_fix = neg ? data_t'(-qc[DATA_W-1:0]) : data_t'(qc[DATA_W-1:0]);
	endfunction

endpackage

// ===== hw/rtl/poxc_queue.sv =====
// ---------------------------------------------------------------------------
// poxc_queue
// Small first-in first-out queue between the front and the back part.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module poxc_queue import poxc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head_item
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	`POXC_NEVER(a_q_overflow, push && full && !pop, "queue written while full")
	`POXC_ASSERT(a_q_underflow, pop |-> cnt_q != '0, "queue read while empty")

endmodule

// ===== hw/rtl/poxc_front.sv =====
// ---------------------------------------------------------------------------
// poxc_front
// Register file, derived constants, and intake of voxel transactions.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module poxc_front import poxc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  data_t             oxygen_counts,
	input  data_t             flow_value,
	input  data_t             volume_value,
	input  logic              last_voxel,
	input  logic              q_full,
	output logic              q_push,
	output item_t             q_item,
	output cfg_t              cfg
);

	localparam int SW = $clog2(SETTLE_CYC + 1);

	logic              mode_q;
	data_t             wa_q, wb_q, oa_q, ob_q, boc_q, pet_q, scale_q;
	data_t             c1_q, c2_q, c3_q;
	logic [CMAG_W-1:0] p1_q, e1_q, p2_q, e2_q, p3_q, e3_q;
	logic              n1_q, n2_q, n3_q;
	logic [SW-1:0]     settle_q;
	logic              cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			wa_q    <= '0;
			wb_q    <= '0;
			oa_q    <= '0;
			ob_q    <= '0;
			boc_q   <= '0;
			pet_q   <= '0;
			scale_q <= DATA_W'(64'd1 << FRAC_W);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MODE:     mode_q  <= cfg_data[0];
				REG_WATER_A:  wa_q    <= cfg_data;
				REG_WATER_B:  wb_q    <= cfg_data;
				REG_OXY_A:    oa_q    <= cfg_data;
				REG_OXY_B:    ob_q    <= cfg_data;
				REG_BLOOD_O2: boc_q   <= cfg_data;
				REG_PET_CONV: pet_q   <= cfg_data;
				REG_SCALE:    scale_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Derived constants: c1 = boc*17/2000, c2 = c1*167/200, c3 = pet*20/21
	always_ff @(posedge clk) begin
		p1_q <= CMAG_W'(mag(boc_q)) * CMAG_W'(17);
		e1_q <= cd_est(CMAG_W'(mag(boc_q)) * CMAG_W'(17), RCP_2000);
		n1_q <= boc_q[DATA_W-1];
		c1_q <= cd_fix(p1_q, e1_q, 12'd2000, n1_q);
		p2_q <= CMAG_W'(mag(c1_q)) * CMAG_W'(167);
		e2_q <= cd_est(CMAG_W'(mag(c1_q)) * CMAG_W'(167), RCP_200);
		n2_q <= c1_q[DATA_W-1];
		c2_q <= cd_fix(p2_q, e2_q, 12'd200, n2_q);
		p3_q <= CMAG_W'(mag(pet_q)) * CMAG_W'(20);
		e3_q <= cd_est(CMAG_W'(mag(pet_q)) * CMAG_W'(20), RCP_21);
		n3_q <= pet_q[DATA_W-1];
		c3_q <= cd_fix(p3_q, e3_q, 12'd21, n3_q);
	end

	// Hold off intake until derived constants have settled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SW'(SETTLE_CYC);
		end else if (cfg_we) begin
			settle_q <= SW'(SETTLE_CYC);
		end else if (settle_q != '0) begin
			settle_q <= settle_q - SW'(1);
		end
	end

	assign in_ready = !q_full && (settle_q == '0);
	assign q_push   = in_valid && in_ready;

	// Classify: a zero oxygen count short-circuits to a zero result
	always_comb begin
		q_item.x1       = oxygen_counts;
		q_item.x2       = flow_value;
		q_item.x3       = volume_value;
		q_item.last     = last_voxel;
		q_item.zero_cnt = (oxygen_counts == '0);
	end

	always_comb begin
		cfg.mode  = mode_q;
		cfg.wa    = wa_q;
		cfg.wb    = wb_q;
		cfg.oa    = oa_q;
		cfg.ob    = ob_q;
		cfg.scale = scale_q;
		cfg.c1    = c1_q;
		cfg.c2    = c2_q;
		cfg.c3    = c3_q;
	end

	`POXC_ASSERT(a_cfg_holds_intake, cfg_we |=> !in_ready, "intake open right after a write")

endmodule

// ===== hw/rtl/poxc_divider.sv =====
// ---------------------------------------------------------------------------
// poxc_divider
// Pipelined restoring divider, one quotient bit per stage, (n << F) / d.
// ---------------------------------------------------------------------------
module poxc_divider import poxc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  umag_t            in_num,
	input  umag_t            in_den,
	input  ctl_t             in_ctl,
	output logic             out_valid,
	output logic [QUO_W-1:0] out_quo,
	output ctl_t             out_ctl
);

	logic             vld_s [QUO_W+1];
	logic [QUO_W-1:0] dvd_s [QUO_W+1];
	logic [QUO_W-1:0] quo_s [QUO_W+1];
	umag_t            rem_s [QUO_W+1];
	umag_t            den_s [QUO_W+1];
	ctl_t             ctl_s [QUO_W+1];

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s[0] <= {in_num, {FRAC_W{1'b0}}};
			quo_s[0] <= '0;
			rem_s[0] <= '0;
			den_s[0] <= in_den;
			ctl_s[0] <= in_ctl;
		end
	end

	// One trial subtract per stage
	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		logic [DATA_W:0] trial;
		logic            fits;

		assign trial = {rem_s[i], dvd_s[i][QUO_W-1]};
		assign fits  = (trial >= {1'b0, den_s[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= fits ? DATA_W'(trial - {1'b0, den_s[i]}) : trial[DATA_W-1:0];
				quo_s[i+1] <= {quo_s[i][QUO_W-2:0], fits};
				dvd_s[i+1] <= {dvd_s[i][QUO_W-2:0], 1'b0};
				den_s[i+1] <= den_s[i];
				ctl_s[i+1] <= ctl_s[i];
			end
		end
	end

	assign out_valid = vld_s[QUO_W];
	assign out_quo   = quo_s[QUO_W];
	assign out_ctl   = ctl_s[QUO_W];

endmodule

// ===== hw/rtl/poxc_back.sv =====
// ---------------------------------------------------------------------------
// poxc_back
// Arithmetic pipeline: numerator, denominator, scaling, division, output.
// ---------------------------------------------------------------------------
module poxc_back import poxc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  q_valid,
	input  item_t q_item,
	output logic  q_pop,
	output logic  out_valid,
	input  logic  out_ready,
	output data_t voxel_result,
	output logic  zero_divisor,
	output logic  last_result
);

	logic             en;
	logic             v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6;
	ctl_t             ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	data_t            a1_s1, a3_s1, a5_s1, mwa_s1, moa_s1, ms_s1, x2_s1;
	data_t            a1_s2, a3_s2, a5_s2, tw_s2, to_s2, ms_s2, x2_s2;
	data_t            a1_s3, a2_s3, a3_s3, a4_s3, a5_s3, ms_s3;
	data_t            d1_s4, den_s4, a3_s4, scl_s4;
	data_t            num_s5, den_s5, scl_s5;
	data_t            prod;
	umag_t            pm_s6, dm_s6;
	logic             dv_valid;
	logic [QUO_W-1:0] dv_quo;
	logic [QUO_W-1:0] quo_lim;
	ctl_t             dv_ctl;
	data_t            res;
	logic             out_valid_q;
	data_t            result_q;
	logic             zero_div_q;
	logic             last_q;

	// Whole pipeline moves when the output register can take a result
	assign en    = !out_valid_q || out_ready;
	assign q_pop = en && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
			v6_s6 <= 1'b0;
		end else if (en) begin
			v1_s1 <= q_valid;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
			v5_s5 <= v4_s4;
			v6_s6 <= v5_s5;
		end
	end

	assign prod = fmul(scl_s5, num_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: products against the voxel fields
			a1_s1           <= fmul(cfg.c3, q_item.x1);
			a3_s1           <= fmul(cfg.c1, q_item.x3);
			a5_s1           <= fmul(cfg.c2, q_item.x3);
			mwa_s1          <= fmul(cfg.wa, q_item.x2);
			moa_s1          <= fmul(cfg.oa, q_item.x2);
			ms_s1           <= fmul(cfg.scale, q_item.x2);
			x2_s1           <= q_item.x2;
			ctl_s1.zero_cnt <= q_item.zero_cnt;
			ctl_s1.zero_den <= 1'b0;
			ctl_s1.last     <= q_item.last;
			ctl_s1.neg      <= 1'b0;
			// s2: linear terms
			tw_s2 <= sat_add(mwa_s1, cfg.wb);
			to_s2 <= sat_add(moa_s1, cfg.ob);
			a1_s2 <= a1_s1;
			a3_s2 <= a3_s1;
			a5_s2 <= a5_s1;
			ms_s2 <= ms_s1;
			x2_s2 <= x2_s1;
			ctl_s2 <= ctl_s1;
			// s3: flow times the polynomials
			a2_s3 <= fmul(x2_s2, tw_s2);
			a4_s3 <= fmul(x2_s2, to_s2);
			a1_s3 <= a1_s2;
			a3_s3 <= a3_s2;
			a5_s3 <= a5_s2;
			ms_s3 <= ms_s2;
			ctl_s3 <= ctl_s2;
			// s4: first difference, denominator, scale select
			d1_s4  <= sat_sub(a1_s3, a2_s3);
			den_s4 <= sat_sub(a4_s3, a5_s3);
			a3_s4  <= a3_s3;
			scl_s4 <= cfg.mode ? ms_s3 : cfg.scale;
			ctl_s4 <= {ctl_s3.zero_cnt, (a4_s3 == a5_s3), ctl_s3.last, ctl_s3.neg};
			// s5: numerator
			num_s5 <= sat_sub(d1_s4, a3_s4);
			den_s5 <= den_s4;
			scl_s5 <= scl_s4;
			ctl_s5 <= ctl_s4;
			// s6: scaled numerator, magnitudes and sign for the divider
			pm_s6  <= mag(prod);
			dm_s6  <= mag(den_s5);
			ctl_s6 <= {ctl_s5.zero_cnt, ctl_s5.zero_den, ctl_s5.last,
				prod[DATA_W-1] ^ den_s5[DATA_W-1]};
		end
	end

	poxc_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v6_s6),
		.in_num    (pm_s6),
		.in_den    (dm_s6),
		.in_ctl    (ctl_s6),
		.out_valid (dv_valid),
		.out_quo   (dv_quo),
		.out_ctl   (dv_ctl)
	);

	// Saturate quotient, apply sign, OEF clamp, special cases
	always_comb begin
		quo_lim = dv_ctl.neg ? QUO_W'(mag(DATA_MIN)) : QUO_W'(DATA_MAX);
		if (dv_quo < quo_lim) quo_lim = dv_quo;
		res = dv_ctl.neg ? data_t'(-quo_lim[DATA_W-1:0]) : data_t'(quo_lim[DATA_W-1:0]);
		if (!cfg.mode) begin
			if (res < 0) begin
				res = '0;
			end else if (res > OEF_TOP) begin
				res = OEF_TOP;
			end
		end
		if (dv_ctl.zero_cnt || dv_ctl.zero_den) res = '0;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && dv_valid) begin
			result_q   <= res;
			zero_div_q <= dv_ctl.zero_den && !dv_ctl.zero_cnt;
			last_q     <= dv_ctl.last;
		end
	end

	assign out_valid    = out_valid_q;
	assign voxel_result = result_q;
	assign zero_divisor = zero_div_q;
	assign last_result  = last_q;

endmodule

// ===== hw/rtl/pet_oxygen_voxel_calc.sv =====
// ---------------------------------------------------------------------------
// pet_oxygen_voxel_calc
// Per-voxel OEF / CMRO2 calculator in signed Q16.16 fixed point.
// ---------------------------------------------------------------------------
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------
// cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
// in       | in_valid/in_ready    | oxygen_counts, flow_value, volume_value,
//          |                      | last_voxel
// out      | out_valid/out_ready  | voxel_result, zero_divisor, last_result
//
// One voxel per cycle sustained while in_ready is high and out_ready keeps up; path: queue, six
// arithmetic stages, a divider input stage and 48 stages (one quotient bit each), output reg.
// in_ready stays low after reset and after each register write
// while the derived constants c1, c2, c3 settle.
// out_ready low while out_valid is high stalls the whole back pipeline; the queue keeps intake going until full.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pet_oxygen_voxel_calc import poxc_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  data_t             oxygen_counts,
	input  data_t             flow_value,
	input  data_t             volume_value,
	input  logic              last_voxel,
	output logic              out_valid,
	input  logic              out_ready,
	output data_t             voxel_result,
	output logic              zero_divisor,
	output logic              last_result
);

	cfg_t  cfg;
	logic  q_full, q_push, q_pop, q_valid;
	item_t q_in, q_out;

	poxc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.oxygen_counts (oxygen_counts),
		.flow_value    (flow_value),
		.volume_value  (volume_value),
		.last_voxel    (last_voxel),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (q_in),
		.cfg           (cfg)
	);

	poxc_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_item  (q_out)
	);

	poxc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_valid      (q_valid),
		.q_item       (q_out),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.voxel_result (voxel_result),
		.zero_divisor (zero_divisor),
		.last_result  (last_result)
	);

	`POXC_ASSERT(a_zero_div_result, out_valid && zero_divisor |-> voxel_result == '0, "flagged result not zero")

endmodule
